// ===== design/stdm_pkg.sv =====
`timescale 1ns / 1ps

package stdm_pkg;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned SizeW   = 11;
  localparam int unsigned ChanW   = 2;
  localparam int unsigned SampleW = 8;

  // Q2.16 normalized coordinate limits
  localparam int unsigned QW     = 18;
  localparam int unsigned FracW  = 16;
  localparam int          OneQ   = 65536;
  localparam int          QMax   = 131071;

  localparam int unsigned AccW = 34;
  localparam int unsigned ResW = 36;

  localparam int unsigned SizeReset = 512;
  localparam int unsigned MinSide   = 2;

  // quotient bits of the normalizing divide, root bits of the square root
  localparam int unsigned DivSteps  = 18;
  localparam int unsigned SqrtSteps = 17;

  typedef struct packed {
    logic signed [1:0][QW-1:0] coord;
    logic        [1:0][AccW-1:0] acc;
    logic        [1:0][ResW-1:0] res;
    logic        [1:0]           sat;
    logic        [ChanW-1:0]     chan;
    logic        [SampleW-1:0]   smp;
  } stg_t;

endpackage

// ===== design/square_to_disc_pixel_remap_unit.sv =====
`timescale 1ns / 1ps

// Elliptical-grid square-to-disc remap. Each transfer on the input channel is
// one channel sample of a source pixel; the block returns one write command
// (dst_row, dst_col, channel, sample) for an external frame store. It takes one
// transfer per clock while the output is not stalled. The pipeline consists of
// the 18-step restoring divide that normalizes the coordinates by the image
// size and the 17-step square root, each step one pipeline stage, plus seven
// stages of capture, normalizing, squaring, radicand, multiply, scaling and
// clamping. A stall on a valid output freezes the whole pipeline and is
// reflected on in_stall_o in the same cycle. The image size register is taken
// with cfg_ready_o always high; write it only while no transfer is in flight.
// Sizes below 2 act as 2, above 1024 as 1024.
module square_to_disc_pixel_remap_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [stdm_pkg::SizeW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [stdm_pkg::CoordW-1:0] src_row_i,
  input  logic [stdm_pkg::CoordW-1:0] src_col_i,
  input  logic [stdm_pkg::ChanW-1:0]  channel_i,
  input  logic [stdm_pkg::SampleW-1:0] sample_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [stdm_pkg::CoordW-1:0] dst_row_o,
  output logic [stdm_pkg::CoordW-1:0] dst_col_o,
  output logic [stdm_pkg::ChanW-1:0]  out_channel_o,
  output logic [stdm_pkg::SampleW-1:0] out_sample_o
);
  import stdm_pkg::*;

  localparam int unsigned MaxSide  = 1024;
  localparam int unsigned DivFirst = 1;
  localparam int unsigned NormStg  = DivFirst + DivSteps;
  localparam int unsigned SqStg    = NormStg + 1;
  localparam int unsigned RadStg   = SqStg + 1;
  localparam int unsigned SqrtFirst = RadStg + 1;
  localparam int unsigned MulStg   = SqrtFirst + SqrtSteps;
  localparam int unsigned ScaleStg = MulStg + 1;
  localparam int unsigned OutStg   = ScaleStg + 1;
  localparam int unsigned NumStg   = OutStg + 1;

  logic [SizeW-1:0] cfg_q;
  logic [SizeW-1:0] neff;
  logic [SizeW-2:0] half;
  logic             adv;

  stg_t pipe_d [NumStg];
  stg_t pipe_q [NumStg];
  logic [NumStg-1:0] vld_d, vld_q;

  // Size register; clamp to the supported range once, shared by all stages.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= SizeW'(SizeReset);
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    priority if (cfg_q < SizeW'(MinSide)) begin
      neff = SizeW'(MinSide);
    end else if (cfg_q > SizeW'(MaxSide)) begin
      neff = SizeW'(MaxSide);
    end else begin
      neff = cfg_q;
    end
  end

  assign half = neff[SizeW-1:1];

  // Global advance: hold everything while the output register is stalled.
  assign adv        = !(vld_q[NumStg-1] && out_stall_i);
  assign in_stall_o = !adv;

  // Capture: dividend is the coordinate times 2^17; flag rows or columns at or
  // past 2N, whose quotient would not fit and saturates anyway.
  always_comb begin
    pipe_d[0]          = '0;
    pipe_d[0].chan     = channel_i;
    pipe_d[0].smp      = sample_i;
    pipe_d[0].acc[0]   = AccW'({src_row_i, 17'b0});
    pipe_d[0].acc[1]   = AccW'({src_col_i, 17'b0});
    pipe_d[0].sat[0]   = {2'b0, src_row_i} >= {neff, 1'b0};
    pipe_d[0].sat[1]   = {2'b0, src_col_i} >= {neff, 1'b0};
    vld_d[0]           = in_valid_i;
  end

  // Restoring divide, one quotient bit per stage, MSB first.
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    localparam int unsigned K = DivSteps - 1 - i;
    always_comb begin
      logic [AccW-1:0] nk;
      nk = AccW'(neff) << K;
      pipe_d[DivFirst+i] = pipe_q[DivFirst+i-1];
      for (int l = 0; l < 2; l++) begin
        if (pipe_q[DivFirst+i-1].acc[l] >= nk) begin
          pipe_d[DivFirst+i].acc[l]    = pipe_q[DivFirst+i-1].acc[l] - nk;
          pipe_d[DivFirst+i].res[l][K] = 1'b1;
        end
      end
      vld_d[DivFirst+i] = vld_q[DivFirst+i-1];
    end
  end

  // Normalize: q - 1.0, saturated to the top of Q2.16.
  always_comb begin
    logic signed [QW:0] diff;
    pipe_d[NormStg] = pipe_q[NormStg-1];
    for (int l = 0; l < 2; l++) begin
      diff = $signed({1'b0, pipe_q[NormStg-1].res[l][QW-1:0]}) - (QW+1)'(OneQ);
      if (pipe_q[NormStg-1].sat[l] || diff > (QW+1)'(QMax)) begin
        pipe_d[NormStg].coord[l] = QW'(QMax);
      end else begin
        pipe_d[NormStg].coord[l] = diff[QW-1:0];
      end
    end
    vld_d[NormStg] = vld_q[NormStg-1];
  end

  // Square the other axis: lane 0 needs x^2, lane 1 needs y^2.
  always_comb begin
    logic signed [2*QW-1:0] sq;
    pipe_d[SqStg] = pipe_q[SqStg-1];
    for (int l = 0; l < 2; l++) begin
      sq = $signed(pipe_q[SqStg-1].coord[1-l]) * $signed(pipe_q[SqStg-1].coord[1-l]);
      pipe_d[SqStg].res[l] = ResW'(unsigned'(sq));
    end
    vld_d[SqStg] = vld_q[SqStg-1];
  end

  // Radicand 1 - b^2/2 in Q16, floored at zero, then scaled by 2^16.
  always_comb begin
    logic [18:0] sh;
    logic [16:0] r;
    pipe_d[RadStg] = pipe_q[RadStg-1];
    for (int l = 0; l < 2; l++) begin
      sh = pipe_q[RadStg-1].res[l][35:17];
      r  = (sh > 19'(OneQ)) ? 17'd0 : 17'(19'(OneQ) - sh);
      pipe_d[RadStg].acc[l] = AccW'({r, 16'b0});
      pipe_d[RadStg].res[l] = '0;
    end
    vld_d[RadStg] = vld_q[RadStg-1];
  end

  // Digit-by-digit square root, one result bit per stage.
  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    localparam int unsigned M = SqrtSteps - 1 - j;
    always_comb begin
      logic [AccW-1:0] bitv;
      logic [AccW-1:0] trial;
      bitv = AccW'(1) << (2 * M);
      pipe_d[SqrtFirst+j] = pipe_q[SqrtFirst+j-1];
      for (int l = 0; l < 2; l++) begin
        trial = pipe_q[SqrtFirst+j-1].res[l][AccW-1:0] + bitv;
        if (pipe_q[SqrtFirst+j-1].acc[l] >= trial) begin
          pipe_d[SqrtFirst+j].acc[l] = pipe_q[SqrtFirst+j-1].acc[l] - trial;
          pipe_d[SqrtFirst+j].res[l] =
            ResW'(pipe_q[SqrtFirst+j-1].res[l][AccW-1:1]) + ResW'(bitv);
        end else begin
          pipe_d[SqrtFirst+j].res[l] = ResW'(pipe_q[SqrtFirst+j-1].res[l][AccW-1:1]);
        end
      end
      vld_d[SqrtFirst+j] = vld_q[SqrtFirst+j-1];
    end
  end

  // a * sqrt(...), Q16 x Q16.
  always_comb begin
    logic signed [QW-1:0] s;
    pipe_d[MulStg] = pipe_q[MulStg-1];
    for (int l = 0; l < 2; l++) begin
      s = $signed({1'b0, pipe_q[MulStg-1].res[l][16:0]});
      pipe_d[MulStg].res[l] = ResW'($signed(pipe_q[MulStg-1].coord[l]) * s);
    end
    vld_d[MulStg] = vld_q[MulStg-1];
  end

  // Floor to Q16, shift by 1.0, drop negatives, scale by floor(N/2).
  always_comb begin
    logic signed [ResW-FracW:0] t;
    pipe_d[ScaleStg] = pipe_q[ScaleStg-1];
    for (int l = 0; l < 2; l++) begin
      t = $signed({pipe_q[ScaleStg-1].res[l][ResW-1],
                   pipe_q[ScaleStg-1].res[l][ResW-1:FracW]}) + (ResW-FracW+1)'(OneQ);
      if (t < 0) begin
        pipe_d[ScaleStg].res[l] = '0;
      end else begin
        pipe_d[ScaleStg].res[l] = ResW'(t[QW-1:0] * half);
      end
    end
    vld_d[ScaleStg] = vld_q[ScaleStg-1];
  end

  // Truncate and clamp to N-1.
  always_comb begin
    logic [11:0] u;
    pipe_d[OutStg] = pipe_q[OutStg-1];
    for (int l = 0; l < 2; l++) begin
      u = pipe_q[OutStg-1].res[l][27:16];
      if (u > 12'(neff - 1'b1)) begin
        u = 12'(neff - 1'b1);
      end
      pipe_d[OutStg].res[l] = ResW'(u);
    end
    vld_d[OutStg] = vld_q[OutStg-1];
  end

  // Pipeline registers: valid bits reset, payload does not.
  for (genvar g = 0; g < NumStg; g++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (adv) begin
        vld_q[g] <= vld_d[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pipe_q[g] <= pipe_d[g];
      end
    end
  end

  assign out_valid_o   = vld_q[NumStg-1];
  assign dst_row_o     = pipe_q[NumStg-1].res[0][CoordW-1:0];
  assign dst_col_o     = pipe_q[NumStg-1].res[1][CoordW-1:0];
  assign out_channel_o = pipe_q[NumStg-1].chan;
  assign out_sample_o  = pipe_q[NumStg-1].smp;

  // Destinations never leave the image.
  a_row_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, dst_row_o} < neff)
    else $error("dst_row outside image");

  a_col_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, dst_col_o} < neff)
    else $error("dst_col outside image");

  // A stalled output freezes the capture stage as well.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(vld_q[0]))
    else $error("pipeline advanced under stall");

endmodule
